@@ src/assert_macros.svh @@
// Assertion helpers included by vector_direction_length_3d.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock, quiet while reset is high.
`define VDL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock, reset included.
`define VDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/vdl_pkg.sv @@
// ----------------------------------------------------------------------------
// vdl_pkg
// Types and widths shared by the vector direction and length pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vdl_pkg;

   localparam int COORD_BITS     = 16;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int MAG_BITS       = COORD_BITS;
   localparam int SQ_BITS        = 2 * MAG_BITS;
   localparam int SUM_BITS       = SQ_BITS + 2;
   localparam int EXTRA_FRAC     = 8;
   localparam int RAD_BITS       = SUM_BITS + 2 * EXTRA_FRAC;
   localparam int LEN_BITS       = RAD_BITS / 2;
   localparam int REM_BITS       = LEN_BITS + 1;
   localparam int UNIT_FRAC_BITS = 14;
   localparam int QUO_BITS       = UNIT_FRAC_BITS + 1;
   localparam int UNIT_BITS      = UNIT_FRAC_BITS + 2;
   localparam int SQRT_CELLS     = LEN_BITS;
   localparam int DIV_CELLS      = QUO_BITS;
   localparam int AXES           = 3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] from_x;
      logic signed [COORD_BITS-1:0] from_y;
      logic signed [COORD_BITS-1:0] from_z;
      logic signed [COORD_BITS-1:0] to_x;
      logic signed [COORD_BITS-1:0] to_y;
      logic signed [COORD_BITS-1:0] to_z;
   } req_type;

   typedef struct packed {
      logic        [LEN_BITS-1:0]  length;
      logic signed [UNIT_BITS-1:0] unit_x;
      logic signed [UNIT_BITS-1:0] unit_y;
      logic signed [UNIT_BITS-1:0] unit_z;
      logic                        zero_vector;
   } rsp_type;

   // One step of the square root: radicand bits still to come, remainder, root so far.
   typedef struct packed {
      logic [RAD_BITS-1:0] rad;
      logic [REM_BITS-1:0] rem;
      logic [LEN_BITS-1:0] root;
   } sqrt_state_type;

   // One step of the divider: remainder, divisor, quotient so far.
   typedef struct packed {
      logic [LEN_BITS-1:0] rem;
      logic [LEN_BITS-1:0] len;
      logic [QUO_BITS-1:0] quo;
   } div_state_type;

endpackage

`default_nettype wire

@@ src/vdl_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// vdl_sqrt_cell
// One digit of a restoring square root; registers the step for its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vdl_sqrt_cell (
   input  wire                   clock,
   input  wire                   en,
   input  vdl_pkg::sqrt_state_type state_in,
   output vdl_pkg::sqrt_state_type state_out
);

   logic [vdl_pkg::REM_BITS+1:0] cur;
   logic [vdl_pkg::REM_BITS+1:0] trial;
   logic                         take;
   vdl_pkg::sqrt_state_type      state_in_w;
   vdl_pkg::sqrt_state_type      state_ff;

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      cur   = {state_in.rem, state_in.rad[vdl_pkg::RAD_BITS-1 -: 2]};
      trial = {1'b0, state_in.root, 2'b01};
      take  = (cur >= trial);
      state_in_w.rad  = {state_in.rad[vdl_pkg::RAD_BITS-3:0], 2'b00};
      if (take) begin
         state_in_w.rem = vdl_pkg::REM_BITS'(cur - trial);
      end else begin
         state_in_w.rem = vdl_pkg::REM_BITS'(cur);
      end
      state_in_w.root = {state_in.root[vdl_pkg::LEN_BITS-2:0], take};
   end

   // Advance the step
   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in_w;
      end
   end

   assign state_out = state_ff;

endmodule

`default_nettype wire

@@ src/vdl_div_cell.sv @@
// ----------------------------------------------------------------------------
// vdl_div_cell
// One quotient bit of a restoring divider; registers the step for its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vdl_div_cell (
   input  wire                          clock,
   input  wire                          en,
   input  wire  [vdl_pkg::LEN_BITS:0]   part_in,
   input  wire  [vdl_pkg::LEN_BITS-1:0] len_in,
   input  wire  [vdl_pkg::QUO_BITS-1:0] quo_in,
   output vdl_pkg::div_state_type       state_out
);

   logic                    take;
   vdl_pkg::div_state_type  state_in_w;
   vdl_pkg::div_state_type  state_ff;

   // Subtract the divisor where it fits
   always_comb begin
      take = (part_in >= {1'b0, len_in});
      if (take) begin
         state_in_w.rem = vdl_pkg::LEN_BITS'(part_in - {1'b0, len_in});
      end else begin
         state_in_w.rem = vdl_pkg::LEN_BITS'(part_in);
      end
      state_in_w.len = len_in;
      state_in_w.quo = {quo_in[vdl_pkg::QUO_BITS-2:0], take};
   end

   // Advance the step
   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in_w;
      end
   end

   assign state_out = state_ff;

endmodule

`default_nettype wire

@@ src/vector_direction_length_3d.sv @@
// ----------------------------------------------------------------------------
// vector_direction_length_3d
// Length and unit direction of the difference of two 3-D points.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless the output stalls, and returns one result
// beat per input beat, in order: the differences are combinational, registers
// then hold the magnitudes, squares and sum, a row of 25 square-root cells
// yields one length bit each, and three rows of 15 divider cells yield one bit
// of a unit component per cell, followed by the output register. A stall
// on the result side holds every stage, so req_stall follows rsp_stall while
// a result is waiting; bubbles move along with the data.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vector_direction_length_3d (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  vdl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output vdl_pkg::rsp_type rsp_data
);

   localparam int NS = vdl_pkg::SQRT_CELLS;
   localparam int ND = vdl_pkg::DIV_CELLS;
   localparam int NA = vdl_pkg::AXES;

   logic en;

   logic signed [vdl_pkg::DIFF_BITS-1:0] diff [NA];
   logic [vdl_pkg::MAG_BITS-1:0] mag1_ff [NA];
   logic [vdl_pkg::MAG_BITS-1:0] mag2_ff [NA];
   logic [vdl_pkg::MAG_BITS-1:0] mag3_ff [NA];
   logic [NA-1:0]                neg1_ff, neg2_ff, neg3_ff;
   logic [vdl_pkg::SQ_BITS-1:0]  sq2_ff [NA];
   logic [vdl_pkg::SUM_BITS-1:0] sum3_ff;
   logic                         zero2_ff, zero3_ff;
   logic                         v1_ff, v2_ff, v3_ff;

   vdl_pkg::sqrt_state_type      sq_st [NS+1];
   logic [vdl_pkg::MAG_BITS-1:0] sq_mag_ff [NS][NA];
   logic [NA-1:0]                sq_neg_ff [NS];
   logic [NS-1:0]                sq_zero_ff, sq_v_ff;

   vdl_pkg::div_state_type       dv_st [NA][ND];
   logic [NA-1:0]                dv_neg_ff [ND];
   logic [ND-1:0]                dv_zero_ff, dv_v_ff;

   logic [vdl_pkg::QUO_BITS-1:0]  sat [NA];
   logic signed [vdl_pkg::UNIT_BITS-1:0] unit [NA];
   vdl_pkg::rsp_type              rsp_in;
   vdl_pkg::rsp_type              rsp_ff;
   logic                          rsp_valid_ff;

   // Hold everything while a result waits on a stalled output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Form the differences
   always_comb begin
      diff[0] = vdl_pkg::DIFF_BITS'(req_data.to_x) - vdl_pkg::DIFF_BITS'(req_data.from_x);
      diff[1] = vdl_pkg::DIFF_BITS'(req_data.to_y) - vdl_pkg::DIFF_BITS'(req_data.from_y);
      diff[2] = vdl_pkg::DIFF_BITS'(req_data.to_z) - vdl_pkg::DIFF_BITS'(req_data.from_z);
   end

   // Magnitudes, squares and sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NA; a++) begin
            neg1_ff[a] <= diff[a][vdl_pkg::DIFF_BITS-1];
            if (diff[a][vdl_pkg::DIFF_BITS-1]) begin
               mag1_ff[a] <= vdl_pkg::MAG_BITS'(-diff[a]);
            end else begin
               mag1_ff[a] <= vdl_pkg::MAG_BITS'(diff[a]);
            end
            sq2_ff[a]  <= mag1_ff[a] * mag1_ff[a];
            mag2_ff[a] <= mag1_ff[a];
            mag3_ff[a] <= mag2_ff[a];
         end
         neg2_ff  <= neg1_ff;
         neg3_ff  <= neg2_ff;
         zero2_ff <= (mag1_ff[0] == '0) && (mag1_ff[1] == '0) && (mag1_ff[2] == '0);
         zero3_ff <= zero2_ff;
         sum3_ff  <= vdl_pkg::SUM_BITS'(sq2_ff[0]) + vdl_pkg::SUM_BITS'(sq2_ff[1])
                     + vdl_pkg::SUM_BITS'(sq2_ff[2]);
      end
   end

   // Feed the root row: radicand is the sum scaled by the extra fraction bits
   assign sq_st[0].rad  = {sum3_ff, {(2 * vdl_pkg::EXTRA_FRAC){1'b0}}};
   assign sq_st[0].rem  = '0;
   assign sq_st[0].root = '0;

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      vdl_sqrt_cell u_cell (
         .clock     (clock),
         .en        (en),
         .state_in  (sq_st[k]),
         .state_out (sq_st[k+1])
      );
   end

   // Carry magnitudes and signs beside the root row
   always_ff @(posedge clock) begin
      if (en) begin
         sq_mag_ff[0]  <= mag3_ff;
         sq_neg_ff[0]  <= neg3_ff;
         sq_zero_ff[0] <= zero3_ff;
         for (int k = 1; k < NS; k++) begin
            sq_mag_ff[k]  <= sq_mag_ff[k-1];
            sq_neg_ff[k]  <= sq_neg_ff[k-1];
            sq_zero_ff[k] <= sq_zero_ff[k-1];
         end
      end
   end

   // Divider lanes, one per axis
   for (genvar a = 0; a < NA; a++) begin : g_lane
      vdl_div_cell u_first (
         .clock     (clock),
         .en        (en),
         .part_in   ({2'b00, sq_mag_ff[NS-1][a], {vdl_pkg::EXTRA_FRAC{1'b0}}}),
         .len_in    (sq_st[NS].root),
         .quo_in    ('0),
         .state_out (dv_st[a][0])
      );
      for (genvar j = 1; j < ND; j++) begin : g_div
         vdl_div_cell u_cell (
            .clock     (clock),
            .en        (en),
            .part_in   ({dv_st[a][j-1].rem, 1'b0}),
            .len_in    (dv_st[a][j-1].len),
            .quo_in    (dv_st[a][j-1].quo),
            .state_out (dv_st[a][j])
         );
      end
   end

   // Carry signs and the zero flag beside the divider rows
   always_ff @(posedge clock) begin
      if (en) begin
         dv_neg_ff[0]  <= sq_neg_ff[NS-1];
         dv_zero_ff[0] <= sq_zero_ff[NS-1];
         for (int j = 1; j < ND; j++) begin
            dv_neg_ff[j]  <= dv_neg_ff[j-1];
            dv_zero_ff[j] <= dv_zero_ff[j-1];
         end
      end
   end

   // Advance the valid bits along the whole pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         sq_v_ff      <= '0;
         dv_v_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         sq_v_ff      <= {sq_v_ff[NS-2:0], v3_ff};
         dv_v_ff      <= {dv_v_ff[ND-2:0], sq_v_ff[NS-1]};
         rsp_valid_ff <= dv_v_ff[ND-1];
      end
   end

   // Clamp, restore sign, drop components of a zero vector
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         if (dv_st[a][ND-1].quo > vdl_pkg::QUO_BITS'(1 << vdl_pkg::UNIT_FRAC_BITS)) begin
            sat[a] = vdl_pkg::QUO_BITS'(1 << vdl_pkg::UNIT_FRAC_BITS);
         end else begin
            sat[a] = dv_st[a][ND-1].quo;
         end
         if (dv_zero_ff[ND-1]) begin
            unit[a] = '0;
         end else if (dv_neg_ff[ND-1][a]) begin
            unit[a] = -vdl_pkg::UNIT_BITS'(sat[a]);
         end else begin
            unit[a] = vdl_pkg::UNIT_BITS'(sat[a]);
         end
      end
      rsp_in.length      = dv_st[0][ND-1].len;
      rsp_in.unit_x      = unit[0];
      rsp_in.unit_y      = unit[1];
      rsp_in.unit_z      = unit[2];
      rsp_in.zero_vector = dv_zero_ff[ND-1];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `VDL_ASSERT(a_zero_len, clock, reset, rsp_valid && rsp_data.zero_vector |-> rsp_data.length == '0 && rsp_data.unit_x == '0 && rsp_data.unit_y == '0 && rsp_data.unit_z == '0, "zero vector with nonzero length or components")
   `VDL_ASSERT(a_len_nonzero, clock, reset, rsp_valid && !rsp_data.zero_vector |-> rsp_data.length != '0, "nonzero vector with zero length")
   `VDL_ASSERT(a_unit_range, clock, reset, rsp_valid |-> rsp_data.unit_x <= 16'sd16384 && rsp_data.unit_x >= -16'sd16384, "unit component out of range")
   `VDL_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3-D vector direction and length pipeline.
// ----------------------------------------------------------------------------
// Drives point pairs on the request channel, computes the expected length,
// unit components and zero flag for each accepted beat, and compares every
// result beat in order. Both sides idle in random bursts; one phase holds the
// result side off for a long stretch so the pipeline fills and stalls.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   vdl_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   vdl_pkg::rsp_type rsp_data;

   vdl_pkg::rsp_type expected_q[$];
   int      fail_count = 0;
   int      sent_count = 0;
   int      got_count = 0;
   int      zero_count = 0;
   int      sender_gaps = 1;
   int      receiver_gaps = 1;
   int      hold_cycles = 0;

   vector_direction_length_3d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // floor(sqrt(x)), bit by bit
   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > x) bits >>= 2;
      while (bits != 0) begin
         if (x >= res + bits) begin
            x -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   // d * 2^22 / len truncated toward zero, clamped to +-1.0
   function automatic logic [vdl_pkg::UNIT_BITS-1:0] unit_of(longint d,
                                                            longint unsigned len);
      longint unsigned mag, q, lim;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = (mag << (vdl_pkg::EXTRA_FRAC + vdl_pkg::UNIT_FRAC_BITS)) / len;
      lim = 64'd1 << vdl_pkg::UNIT_FRAC_BITS;
      if (q > lim) q = lim;
      if (d < 0) q = -q;
      return q[vdl_pkg::UNIT_BITS-1:0];
   endfunction

   function automatic vdl_pkg::rsp_type direction_of(vdl_pkg::req_type r);
      vdl_pkg::rsp_type e;
      longint          dx, dy, dz;
      longint unsigned s, len;
      dx = longint'(r.to_x) - longint'(r.from_x);
      dy = longint'(r.to_y) - longint'(r.from_y);
      dz = longint'(r.to_z) - longint'(r.from_z);
      s = dx * dx + dy * dy + dz * dz;
      len = root_floor(s << (2 * vdl_pkg::EXTRA_FRAC));
      e = '0;
      e.length = len[vdl_pkg::LEN_BITS-1:0];
      if (s == 0) begin
         e.zero_vector = 1'b1;
      end else begin
         e.unit_x = unit_of(dx, len);
         e.unit_y = unit_of(dy, len);
         e.unit_z = unit_of(dz, len);
      end
      return e;
   endfunction

   // Send one beat; hold it until accepted
   task automatic send_points(vdl_pkg::req_type r);
      int gap;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(direction_of(r));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic vdl_pkg::req_type rand_points();
      vdl_pkg::req_type r;
      r = {$urandom, $urandom, $urandom};
      return r;
   endfunction

   // Result side: random stall bursts, or a long counted hold
   initial begin : receiver
      int burst;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      vdl_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count++;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            if (e.zero_vector) zero_count++;
            if (rsp_data.length !== e.length) begin
               $error("length exp %0d got %0d", e.length, rsp_data.length);
               fail_count++;
            end
            if (rsp_data.unit_x !== e.unit_x) begin
               $error("unit_x exp %0d got %0d", e.unit_x, rsp_data.unit_x);
               fail_count++;
            end
            if (rsp_data.unit_y !== e.unit_y) begin
               $error("unit_y exp %0d got %0d", e.unit_y, rsp_data.unit_y);
               fail_count++;
            end
            if (rsp_data.unit_z !== e.unit_z) begin
               $error("unit_z exp %0d got %0d", e.unit_z, rsp_data.unit_z);
               fail_count++;
            end
            if (rsp_data.zero_vector !== e.zero_vector) begin
               $error("zero_vector exp %0d got %0d", e.zero_vector,
                      rsp_data.zero_vector);
               fail_count++;
            end
         end
      end
   end

   task automatic test_extremes();
      vdl_pkg::req_type r;
      logic signed [vdl_pkg::COORD_BITS-1:0] lo, hi, zr, one;
      lo  = -16'sd32768;
      hi  = 16'sd32767;
      zr  = '0;
      one = 16'sd1;
      send_points('0);                                  // zero vector at origin
      r = '{hi, lo, 16'sd5, hi, lo, 16'sd5};
      send_points(r);                                   // coincident points
      send_points('{lo, lo, lo, hi, hi, hi});           // longest diagonal
      send_points('{hi, hi, hi, lo, lo, lo});
      send_points('{lo, zr, zr, hi, zr, zr});           // pure axes
      send_points('{zr, hi, zr, zr, lo, zr});
      send_points('{zr, zr, lo, zr, zr, hi});
      send_points('{zr, zr, zr, one, zr, zr});          // smallest steps
      send_points('{zr, zr, zr, zr, -one, zr});
      send_points('{zr, zr, zr, one, one, one});
      send_points('{zr, zr, zr, zr, zr, lo});           // plain normalization
      send_points('{zr, zr, zr, hi, hi, zr});
      send_points('{one, zr, zr, zr, zr, zr});
      send_points('{-one, -one, -one, hi, hi, hi});
      send_points('{zr, zr, zr, 16'sd3, -16'sd4, 16'sd12});
      send_points('{16'sd100, -16'sd200, 16'sd300, -16'sd100, 16'sd200, -16'sd300});
      go_idle();
   endtask

   task automatic test_random(int count);
      vdl_pkg::req_type r;
      repeat (count) begin
         r = rand_points();
         case ($urandom_range(0, 9))
            0: r.to_x = r.from_x;
            1: begin r.to_x = r.from_x; r.to_y = r.from_y; r.to_z = r.from_z; end
            2: begin r.from_x = '0; r.from_y = '0; r.from_z = '0; end
            3: begin                                    // short vectors
               r.to_x = r.from_x + $signed(4'($urandom));
               r.to_y = r.from_y + $signed(4'($urandom));
               r.to_z = r.from_z + $signed(4'($urandom));
            end
            default: ;
         endcase
         send_points(r);
      end
      go_idle();
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      hold_cycles = 200;
      test_random(120);
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   initial begin : timeout
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : main
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_random(400);
      test_backpressure();
      sender_gaps = 0;
      receiver_gaps = 0;
      test_random(220);
      drain();
      $display("Sent %0d point pairs, checked %0d results (%0d zero vectors).",
               sent_count, got_count, zero_count);
      $display("Covered extremes, random vectors, stall bursts and a long hold.");
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+src
src/vdl_pkg.sv
src/vdl_sqrt_cell.sv
src/vdl_div_cell.sv
src/vector_direction_length_3d.sv
tb/sv/tb_top.sv
